[hdl/tsdr_pkg.sv]
// tsdr_pkg: shared types, constants and helpers of the tile and sprite dot renderer
// no dependencies
`default_nettype none

package tsdr_pkg;

  localparam int VRAM_BYTES       = 8192;
  localparam int VRAM_AW          = 13;
  localparam int OBJ_BYTES        = 160;
  localparam int OBJ_LANES        = 4;
  localparam int OBJ_ROWS         = OBJ_BYTES / OBJ_LANES;
  localparam int FIFO_DEPTH       = 8;
  localparam int DOTS_PER_LINE    = 456;
  localparam int SCREEN_WIDTH_DEF = 160;
  localparam int MAX_SPRITES_DEF  = 10;

  localparam logic [8:0]  SCAN_LAST_DOT    = 9'd79;
  localparam logic [8:0]  SCAN_DOTS        = 9'd80;
  localparam logic [7:0]  VBLANK_LINE      = 8'd144;
  localparam logic [7:0]  LINE_WRAP        = 8'd154;
  localparam logic [12:0] BG_MAP_OFFSET    = 13'h1800;
  localparam logic [12:0] SIGNED_TILE_BASE = 13'h1000;
  localparam logic [8:0]  SPR_Y_OFFSET     = 9'd16;
  localparam logic [8:0]  SPR_Y_HEIGHT     = 9'd8;

  localparam int LCD_ON_BIT       = 7;
  localparam int LCD_UNSIGNED_BIT = 4;
  localparam int FLAG_PAL_BIT     = 4;

  localparam logic [1:0] REQ_TICK   = 2'd0;
  localparam logic [1:0] REQ_VWRITE = 2'd1;
  localparam logic [1:0] REQ_OWRITE = 2'd2;

  localparam logic [2:0] CFG_LCD_CONTROL = 3'd0;
  localparam logic [2:0] CFG_SCROLL_Y    = 3'd1;
  localparam logic [2:0] CFG_BG_PALETTE  = 3'd2;
  localparam logic [2:0] CFG_OBJ_PAL0    = 3'd3;
  localparam logic [2:0] CFG_OBJ_PAL1    = 3'd4;
  localparam logic [2:0] CFG_LINE_CMP    = 3'd5;

  typedef enum logic [1:0] {
    MODE_HBLANK = 2'd0,
    MODE_VBLANK = 2'd1,
    MODE_SCAN   = 2'd2,
    MODE_DRAW   = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    OP_TICK   = 2'd0,
    OP_VWRITE = 2'd1,
    OP_OWRITE = 2'd2,
    OP_NOP    = 2'd3
  } op_t;

  typedef struct packed {
    op_t         op;
    logic [12:0] addr;
    logic [7:0]  data;
  } item_t;

  typedef struct packed {
    logic [7:0] lcd_control;
    logic [7:0] scroll_y;
    logic [7:0] bg_palette;
    logic [7:0] obj_pal0;
    logic [7:0] obj_pal1;
    logic [7:0] line_compare;
  } cfg_t;

  typedef struct packed {
    logic       pixel_valid;
    logic [7:0] pixel_x;
    logic [7:0] pixel_y;
    logic [1:0] shade;
    logic       pixel_blank;
    logic [1:0] video_mode;
    logic [7:0] current_line;
    logic       line_match;
    logic       vblank_pulse;
  } result_t;

  function automatic logic [12:0] tile_addr(input logic [7:0] id, input logic is_obj,
                                            input logic unsigned_mode, input logic [2:0] row,
                                            input logic plane);
    logic [12:0] base;
    base = {1'b0, id, 4'b0000};
    if (!(is_obj || unsigned_mode || id[7])) begin
      base = SIGNED_TILE_BASE + base;
    end
    return base + {9'd0, row, plane};
  endfunction

endpackage

`default_nettype wire

[hdl/tsdr_ram.sv]
// tsdr_ram: generic simple dual-port ram, one write port and one registered read port
// no dependencies
`default_nettype none

module tsdr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

[hdl/tsdr_front.sv]
// tsdr_front: accepts requests, classifies them and queues them for the dot engine
// depends on tsdr_pkg
`default_nettype none

module tsdr_front (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output      logic           in_stall,
  input  wire logic [1:0]     in_req_type,
  input  wire logic [12:0]    in_mem_addr,
  input  wire logic [7:0]     in_mem_data,
  output      tsdr_pkg::item_t q_item,
  output      logic           q_valid,
  input  wire logic           q_pop
);

  tsdr_pkg::item_t q_r [2];
  logic            wr_ptr_r, rd_ptr_r;
  logic [1:0]      count_r;
  tsdr_pkg::item_t cls;
  logic            push;

  always_comb begin
    cls.addr = in_mem_addr;
    cls.data = in_mem_data;
    unique case (in_req_type)
      tsdr_pkg::REQ_TICK:   cls.op = tsdr_pkg::OP_TICK;
      tsdr_pkg::REQ_VWRITE: cls.op = tsdr_pkg::OP_VWRITE;
      tsdr_pkg::REQ_OWRITE: cls.op = (in_mem_addr < 13'(tsdr_pkg::OBJ_BYTES)) ?
                                     tsdr_pkg::OP_OWRITE : tsdr_pkg::OP_NOP;
      default:              cls.op = tsdr_pkg::OP_NOP;
    endcase
  end

  assign in_stall = (count_r == 2'd2);
  assign push     = in_valid && !in_stall;
  assign q_valid  = (count_r != 2'd0);
  assign q_item   = q_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (q_pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      count_r <= count_r + {1'b0, push} - {1'b0, q_pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= cls;
    end
  end

endmodule

`default_nettype wire

[hdl/tsdr_back.sv]
// tsdr_back: dot engine with object scan, tile fetcher, pixel fifos, mixer and timing
// depends on tsdr_pkg and tsdr_ram
`default_nettype none

module tsdr_back #(
  parameter int SCREEN_WIDTH     = tsdr_pkg::SCREEN_WIDTH_DEF,
  parameter int MAX_LINE_SPRITES = tsdr_pkg::MAX_SPRITES_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire tsdr_pkg::cfg_t   cfg,
  input  wire tsdr_pkg::item_t  q_item,
  input  wire logic             q_valid,
  output      logic             q_pop,
  output      logic             out_valid,
  input  wire logic             out_stall,
  output      tsdr_pkg::result_t res
);

  localparam int COL_W  = $clog2(SCREEN_WIDTH + 1);
  localparam int SPR_IW = (MAX_LINE_SPRITES > 1) ? $clog2(MAX_LINE_SPRITES) : 1;
  localparam int OBJ_AW = $clog2(tsdr_pkg::OBJ_ROWS);

  typedef enum logic [1:0] {RD_NONE, RD_TILE, RD_LOW, RD_HIGH} rd_tgt_t;

  logic              execute;
  logic [8:0]        dot_r, dot_nxt;
  logic [7:0]        line_r, line_nxt;
  tsdr_pkg::mode_t   mode_r, mode_nxt;
  logic              match_r, match_nxt;
  logic [3:0]        total_r, total_nxt, next_r, next_nxt;
  logic [2:0]        step_r, step_nxt;
  logic [4:0]        tcol_r, tcol_nxt;
  logic [7:0]        row_y_r, row_y_nxt, tile_r, tile_nxt, plo_r, plo_nxt;
  logic [7:0]        phi_r, phi_nxt, flags_r, flags_nxt;
  logic              is_obj_r, is_obj_nxt, sfetch_r, sfetch_nxt;
  logic [9:0]        bg_fifo_r [tsdr_pkg::FIFO_DEPTH];
  logic [9:0]        bg_fifo_nxt [tsdr_pkg::FIFO_DEPTH];
  logic [9:0]        sp_fifo_r [tsdr_pkg::FIFO_DEPTH];
  logic [9:0]        sp_fifo_nxt [tsdr_pkg::FIFO_DEPTH];
  logic [3:0]        bg_head_r, bg_head_nxt, sp_head_r, sp_head_nxt;
  logic [COL_W-1:0]  col_r, col_nxt;
  logic [31:0]       sprites_r [MAX_LINE_SPRITES];
  logic              spr_we;
  logic [31:0]       spr_wdata;
  rd_tgt_t           tgt_r, tgt_nxt;
  logic              out_valid_r;
  tsdr_pkg::result_t res_r, res_nxt;

  logic              vrd_en;
  logic [12:0]       vrd_addr;
  logic [7:0]        vram_rdata;
  logic              ord_en;
  logic [7:0]        oram_rdata [tsdr_pkg::OBJ_LANES];

  logic [3:0]        sel, sel_eff;
  logic [31:0]       entry;
  logic [9:0]        col_plus;
  logic [8:0]        line_ext, oy_ext;
  logic [9:0]        pix;
  logic [1:0]        color;
  logic [7:0]        pal;
  logic [9:0]        dot_inc;

  assign execute   = q_valid && (!out_valid_r || !out_stall);
  assign q_pop     = execute;
  assign out_valid = out_valid_r;
  assign res       = res_r;

  tsdr_ram #(.WIDTH(8), .DEPTH(tsdr_pkg::VRAM_BYTES)) u_vram (
    .clk   (clk),
    .we    (execute && (q_item.op == tsdr_pkg::OP_VWRITE)),
    .waddr (q_item.addr[tsdr_pkg::VRAM_AW-1:0]),
    .wdata (q_item.data),
    .re    (vrd_en),
    .raddr (vrd_addr),
    .rdata (vram_rdata)
  );

  for (genvar g = 0; g < tsdr_pkg::OBJ_LANES; g++) begin : g_oram
    tsdr_ram #(.WIDTH(8), .DEPTH(tsdr_pkg::OBJ_ROWS)) u_oram (
      .clk   (clk),
      .we    (execute && (q_item.op == tsdr_pkg::OP_OWRITE) && (q_item.addr[1:0] == 2'(g))),
      .waddr (q_item.addr[OBJ_AW+1:2]),
      .wdata (q_item.data),
      .re    (ord_en),
      .raddr (dot_r[OBJ_AW:1]),
      .rdata (oram_rdata[g])
    );
  end

  // one shared read of the line sprite list per cycle
  always_comb begin
    sel     = (step_r == 3'd7 && sfetch_r) ? next_r + 4'd1 : next_r;
    sel_eff = (sel < total_r) ? sel : 4'd0;
    entry   = sprites_r[sel_eff[SPR_IW-1:0]];
  end

  always_comb begin
    dot_nxt     = dot_r;
    line_nxt    = line_r;
    mode_nxt    = mode_r;
    match_nxt   = match_r;
    total_nxt   = total_r;
    next_nxt    = next_r;
    step_nxt    = step_r;
    tcol_nxt    = tcol_r;
    row_y_nxt   = row_y_r;
    tile_nxt    = (tgt_r == RD_TILE) ? vram_rdata : tile_r;
    plo_nxt     = (tgt_r == RD_LOW) ? vram_rdata : plo_r;
    phi_nxt     = (tgt_r == RD_HIGH) ? vram_rdata : phi_r;
    flags_nxt   = flags_r;
    is_obj_nxt  = is_obj_r;
    sfetch_nxt  = sfetch_r;
    bg_fifo_nxt = bg_fifo_r;
    sp_fifo_nxt = sp_fifo_r;
    bg_head_nxt = bg_head_r;
    sp_head_nxt = sp_head_r;
    col_nxt     = col_r;
    spr_we      = 1'b0;
    spr_wdata   = {oram_rdata[0], oram_rdata[1], oram_rdata[2], oram_rdata[3]};
    tgt_nxt     = RD_NONE;
    vrd_en      = 1'b0;
    vrd_addr    = '0;
    ord_en      = 1'b0;
    res_nxt     = '0;
    col_plus    = 10'(col_r) + 10'd8;
    line_ext    = {1'b0, line_r};
    oy_ext      = {1'b0, oram_rdata[0]};
    pix         = '0;
    color       = 2'd0;
    pal         = 8'd0;
    dot_inc     = {1'b0, dot_r} + 10'd1;

    if (execute && q_item.op == tsdr_pkg::OP_TICK) begin
      if (mode_r == tsdr_pkg::MODE_SCAN) begin
        if (dot_r == 9'd0) begin
          total_nxt = 4'd0;
        end
        if (!dot_r[0] && dot_r < tsdr_pkg::SCAN_DOTS) begin
          ord_en = 1'b1;
        end
        // the entry read on the previous even dot is judged here
        if (dot_r[0] && dot_r <= tsdr_pkg::SCAN_LAST_DOT &&
            total_r < 4'(MAX_LINE_SPRITES)) begin
          if (oram_rdata[1] != 8'd0 && oy_ext <= line_ext + tsdr_pkg::SPR_Y_OFFSET &&
              oy_ext > line_ext + tsdr_pkg::SPR_Y_HEIGHT) begin
            spr_we    = 1'b1;
            total_nxt = total_r + 4'd1;
          end
        end
        if (dot_r == tsdr_pkg::SCAN_LAST_DOT) begin
          mode_nxt    = tsdr_pkg::MODE_DRAW;
          col_nxt     = '0;
          sfetch_nxt  = 1'b0;
          bg_head_nxt = 4'(tsdr_pkg::FIFO_DEPTH);
          sp_head_nxt = 4'(tsdr_pkg::FIFO_DEPTH);
          next_nxt    = 4'd0;
          step_nxt    = 3'd0;
          tcol_nxt    = 5'd0;
        end
      end else if (mode_r == tsdr_pkg::MODE_DRAW) begin
        unique case (step_r)
          3'd0: begin
            if (sfetch_r) begin
              row_y_nxt  = line_r - entry[31:24];
              tile_nxt   = entry[15:8];
              flags_nxt  = entry[7:0];
              is_obj_nxt = 1'b1;
            end else begin
              row_y_nxt  = line_r + cfg.scroll_y;
              is_obj_nxt = 1'b0;
              vrd_en     = 1'b1;
              vrd_addr   = tsdr_pkg::BG_MAP_OFFSET + {3'd0, row_y_nxt[7:3], 5'd0} +
                           {8'd0, tcol_r};
              tgt_nxt    = RD_TILE;
            end
          end
          3'd2, 3'd4: begin
            vrd_en   = 1'b1;
            vrd_addr = tsdr_pkg::tile_addr(tile_r, is_obj_r,
                                           cfg.lcd_control[tsdr_pkg::LCD_UNSIGNED_BIT],
                                           row_y_r[2:0], step_r[2]);
            tgt_nxt  = step_r[2] ? RD_HIGH : RD_LOW;
          end
          3'd6: begin
            if (!sfetch_r) begin
              tcol_nxt = tcol_r + 5'd1;
            end
          end
          3'd7: begin
            if (sfetch_r) begin
              if (sp_head_r == 4'(tsdr_pkg::FIFO_DEPTH)) begin
                for (int i = 0; i < tsdr_pkg::FIFO_DEPTH; i++) begin
                  sp_fifo_nxt[i] = {flags_r, phi_r[7-i], plo_r[7-i]};
                end
                sp_head_nxt = 4'd0;
              end
              next_nxt = next_r + 4'd1;
              if (next_nxt >= total_r) begin
                sfetch_nxt = 1'b0;
              end else if ({2'b00, entry[23:16]} > col_plus) begin
                sfetch_nxt = 1'b0;
              end
            end else begin
              if (bg_head_r == 4'(tsdr_pkg::FIFO_DEPTH)) begin
                for (int i = 0; i < tsdr_pkg::FIFO_DEPTH; i++) begin
                  bg_fifo_nxt[i] = {cfg.bg_palette, phi_r[7-i], plo_r[7-i]};
                end
                bg_head_nxt = 4'd0;
              end
              if (next_r < total_r && {2'b00, entry[23:16]} == col_plus) begin
                sfetch_nxt = 1'b1;
              end
            end
          end
          default: begin
          end
        endcase
        step_nxt = step_r + 3'd1;

        // mixer
        if (!sfetch_nxt && bg_head_nxt < 4'(tsdr_pkg::FIFO_DEPTH)) begin
          pix         = bg_fifo_nxt[bg_head_nxt[2:0]];
          color       = pix[1:0];
          pal         = pix[9:2];
          bg_head_nxt = bg_head_nxt + 4'd1;
          if (sp_head_nxt < 4'(tsdr_pkg::FIFO_DEPTH)) begin
            pix         = sp_fifo_nxt[sp_head_nxt[2:0]];
            sp_head_nxt = sp_head_nxt + 4'd1;
            if (pix[1:0] != 2'd0) begin
              color = pix[1:0];
              pal   = pix[2+tsdr_pkg::FLAG_PAL_BIT] ? cfg.obj_pal1 : cfg.obj_pal0;
            end
          end
          if (col_r < COL_W'(SCREEN_WIDTH)) begin
            res_nxt.pixel_valid = 1'b1;
            res_nxt.pixel_x     = 8'(col_r);
            res_nxt.pixel_y     = line_r;
            if (!cfg.lcd_control[tsdr_pkg::LCD_ON_BIT]) begin
              res_nxt.pixel_blank = 1'b1;
            end else begin
              res_nxt.shade = 2'(pal >> {color, 1'b0});
            end
            col_nxt = col_r + COL_W'(1);
          end
        end
        if (col_nxt == COL_W'(SCREEN_WIDTH)) begin
          mode_nxt = tsdr_pkg::MODE_HBLANK;
        end
      end

      // line timing
      dot_nxt = dot_inc[8:0];
      if (dot_inc >= 10'(tsdr_pkg::DOTS_PER_LINE)) begin
        dot_nxt   = 9'd0;
        line_nxt  = line_r + 8'd1;
        match_nxt = (line_nxt == cfg.line_compare);
        if (line_nxt < tsdr_pkg::VBLANK_LINE) begin
          mode_nxt = tsdr_pkg::MODE_SCAN;
        end else if (line_nxt == tsdr_pkg::VBLANK_LINE) begin
          mode_nxt             = tsdr_pkg::MODE_VBLANK;
          res_nxt.vblank_pulse = 1'b1;
        end else if (line_nxt >= tsdr_pkg::LINE_WRAP) begin
          line_nxt = 8'd0;
          mode_nxt = tsdr_pkg::MODE_SCAN;
        end
      end
    end

    res_nxt.video_mode   = mode_nxt;
    res_nxt.current_line = line_nxt;
    res_nxt.line_match   = match_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dot_r       <= 9'd0;
      line_r      <= 8'd0;
      mode_r      <= tsdr_pkg::MODE_SCAN;
      match_r     <= 1'b0;
      total_r     <= 4'd0;
      next_r      <= 4'd0;
      step_r      <= 3'd0;
      tcol_r      <= 5'd0;
      sfetch_r    <= 1'b0;
      bg_head_r   <= 4'(tsdr_pkg::FIFO_DEPTH);
      sp_head_r   <= 4'(tsdr_pkg::FIFO_DEPTH);
      col_r       <= '0;
      tgt_r       <= RD_NONE;
      out_valid_r <= 1'b0;
    end else begin
      tgt_r <= tgt_nxt;
      if (execute) begin
        dot_r       <= dot_nxt;
        line_r      <= line_nxt;
        mode_r      <= mode_nxt;
        match_r     <= match_nxt;
        total_r     <= total_nxt;
        next_r      <= next_nxt;
        step_r      <= step_nxt;
        tcol_r      <= tcol_nxt;
        sfetch_r    <= sfetch_nxt;
        bg_head_r   <= bg_head_nxt;
        sp_head_r   <= sp_head_nxt;
        col_r       <= col_nxt;
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    tile_r <= tile_nxt;
    plo_r  <= plo_nxt;
    phi_r  <= phi_nxt;
    if (execute) begin
      row_y_r   <= row_y_nxt;
      flags_r   <= flags_nxt;
      is_obj_r  <= is_obj_nxt;
      bg_fifo_r <= bg_fifo_nxt;
      sp_fifo_r <= sp_fifo_nxt;
      res_r     <= res_nxt;
    end
    if (spr_we) begin
      sprites_r[total_r[SPR_IW-1:0]] <= spr_wdata;
    end
  end

endmodule

`default_nettype wire

[hdl/tile_sprite_dot_renderer_top.sv]
// tile_sprite_dot_renderer_top: top level of the tile and sprite dot renderer
// depends on tsdr_pkg, tsdr_front, tsdr_back and tsdr_ram
//
// Input requests: a dot tick advances one dot of a line, a video write or object write
// loads the video memory or the object memory. Each request gives exactly one result:
// pixel fields when a pixel is produced, and mode, line, coincidence and vblank status.
// Handshake on both channels is valid/stall; a request moves when valid is high and
// stall is low. Configuration is a plain write port (cfg_we, cfg_index, cfg_data).
// The result of a request passes the request queue and then the result register of
// the dot engine before it is offered.
// Throughput: one request per cycle unless the receiver stalls; the engine retires one
// request per cycle and reads video memory on earlier ticks than those using the bytes.
// A two-entry request queue sits in front of the engine and a result register behind
// it, so a stalled receiver holds the result while up to two more requests are taken.
// Reset (rst_n low, synchronous) clears timing, fetcher and fifo control and loads
// the register defaults; video and object memory keep undefined contents until written.
`default_nettype none

module tile_sprite_dot_renderer_top #(
  parameter int SCREEN_WIDTH     = tsdr_pkg::SCREEN_WIDTH_DEF,
  parameter int MAX_LINE_SPRITES = tsdr_pkg::MAX_SPRITES_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output      logic        in_stall,
  input  wire logic [1:0]  in_req_type,
  input  wire logic [12:0] in_mem_addr,
  input  wire logic [7:0]  in_mem_data,
  output      logic        out_valid,
  input  wire logic        out_stall,
  output      logic        out_pixel_valid,
  output      logic [7:0]  out_pixel_x,
  output      logic [7:0]  out_pixel_y,
  output      logic [1:0]  out_shade,
  output      logic        out_pixel_blank,
  output      logic [1:0]  out_video_mode,
  output      logic [7:0]  out_current_line,
  output      logic        out_line_match,
  output      logic        out_vblank_pulse,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [7:0]  cfg_data
);

  tsdr_pkg::cfg_t    cfg_r;
  tsdr_pkg::item_t   q_item;
  logic              q_valid, q_pop;
  tsdr_pkg::result_t res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.lcd_control  <= 8'd145;
      cfg_r.scroll_y     <= 8'd0;
      cfg_r.bg_palette   <= 8'd252;
      cfg_r.obj_pal0     <= 8'd255;
      cfg_r.obj_pal1     <= 8'd255;
      cfg_r.line_compare <= 8'd0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        tsdr_pkg::CFG_LCD_CONTROL: cfg_r.lcd_control  <= cfg_data;
        tsdr_pkg::CFG_SCROLL_Y:    cfg_r.scroll_y     <= cfg_data;
        tsdr_pkg::CFG_BG_PALETTE:  cfg_r.bg_palette   <= cfg_data;
        tsdr_pkg::CFG_OBJ_PAL0:    cfg_r.obj_pal0     <= cfg_data;
        tsdr_pkg::CFG_OBJ_PAL1:    cfg_r.obj_pal1     <= cfg_data;
        tsdr_pkg::CFG_LINE_CMP:    cfg_r.line_compare <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  tsdr_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_req_type (in_req_type),
    .in_mem_addr (in_mem_addr),
    .in_mem_data (in_mem_data),
    .q_item      (q_item),
    .q_valid     (q_valid),
    .q_pop       (q_pop)
  );

  tsdr_back #(
    .SCREEN_WIDTH     (SCREEN_WIDTH),
    .MAX_LINE_SPRITES (MAX_LINE_SPRITES)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .q_item    (q_item),
    .q_valid   (q_valid),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .res       (res)
  );

  assign out_pixel_valid  = res.pixel_valid;
  assign out_pixel_x      = res.pixel_x;
  assign out_pixel_y      = res.pixel_y;
  assign out_shade        = res.shade;
  assign out_pixel_blank  = res.pixel_blank;
  assign out_video_mode   = res.video_mode;
  assign out_current_line = res.current_line;
  assign out_line_match   = res.line_match;
  assign out_vblank_pulse = res.vblank_pulse;

endmodule

`default_nettype wire

[hdl/tsdr_checker.sv]
// tsdr_checker: port-level assertions for the dot renderer, bound to the top level
// depends on tsdr_pkg and tile_sprite_dot_renderer_top
`default_nettype none

module tsdr_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic        out_pixel_valid,
  input wire logic [7:0]  out_pixel_x,
  input wire logic [7:0]  out_pixel_y,
  input wire logic [1:0]  out_shade,
  input wire logic        out_pixel_blank,
  input wire logic [1:0]  out_video_mode,
  input wire logic [7:0]  out_current_line,
  input wire logic        out_vblank_pulse
);

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped under stall");

  a_no_pixel_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_pixel_valid |->
      out_pixel_x == 8'd0 && out_pixel_y == 8'd0 && out_shade == 2'd0 && !out_pixel_blank)
    else $error("pixel fields set without a pixel");

  a_blank_shade: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_pixel_blank |-> out_pixel_valid && out_shade == 2'd0)
    else $error("blank pixel with a shade");

  a_vblank_line: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_vblank_pulse |->
      out_current_line == tsdr_pkg::VBLANK_LINE &&
      out_video_mode == tsdr_pkg::MODE_VBLANK)
    else $error("vblank request off line start");

  a_line_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_current_line < tsdr_pkg::LINE_WRAP &&
      out_pixel_y < tsdr_pkg::VBLANK_LINE)
    else $error("line counter out of range");

endmodule

bind tile_sprite_dot_renderer_top tsdr_checker u_tsdr_checker (.*);

`default_nettype wire

[tb/sv/tb_top.sv]
// tb_top: self-checking testbench of the tile and sprite dot renderer
// depends on tsdr_pkg and tile_sprite_dot_renderer_top; fills the memory that is read,
// then runs directed and random requests under several register settings
`timescale 1ns / 100ps

module tb_top;

  localparam int          WATCHDOG_LIMIT = 5000;
  localparam logic [12:0] TILE_BASE      = 13'h0800;
  localparam logic [12:0] MAP_BASE       = 13'h1800;
  localparam logic [12:0] MAP_END        = 13'h1bff;

  typedef struct {
    tsdr_pkg::op_t     op;
    logic [12:0]       addr;
    logic [7:0]        data;
    bit                typed;
    tsdr_pkg::result_t res;
  } row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  in_req_type = '0;
  logic [12:0] in_mem_addr = '0;
  logic [7:0]  in_mem_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        out_pixel_valid;
  logic [7:0]  out_pixel_x;
  logic [7:0]  out_pixel_y;
  logic [1:0]  out_shade;
  logic        out_pixel_blank;
  logic [1:0]  out_video_mode;
  logic [7:0]  out_current_line;
  logic        out_line_match;
  logic        out_vblank_pulse;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [7:0]  cfg_data = '0;

  always #1 clk = ~clk;

  tile_sprite_dot_renderer_top i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_req_type(in_req_type),
    .in_mem_addr(in_mem_addr), .in_mem_data(in_mem_data),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_pixel_valid(out_pixel_valid), .out_pixel_x(out_pixel_x),
    .out_pixel_y(out_pixel_y), .out_shade(out_shade), .out_pixel_blank(out_pixel_blank),
    .out_video_mode(out_video_mode), .out_current_line(out_current_line),
    .out_line_match(out_line_match), .out_vblank_pulse(out_vblank_pulse),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // predictor state
  logic [7:0]      vram [tsdr_pkg::VRAM_BYTES];
  logic [7:0]      oram [tsdr_pkg::OBJ_BYTES];
  logic [7:0]      lcd_ctl, scy, bgp, obp0, obp1, lyc;
  int              dot, line, spr_n, spr_next, fstep, tcol, bg_head, sp_head, col;
  tsdr_pkg::mode_t mode;
  logic [31:0]     spr [tsdr_pkg::MAX_SPRITES_DEF];
  logic [7:0]      f_row, f_id, f_lo, f_hi, f_flags;
  bit              f_obj, spr_fetch, match;
  logic [9:0]      bgq [tsdr_pkg::FIFO_DEPTH];
  logic [9:0]      sq [tsdr_pkg::FIFO_DEPTH];

  tsdr_pkg::result_t pending_px[$];
  row_t              typed_q[$];
  int                errors = 0;
  int                idle_cycles = 0;
  bit                calm_in = 1'b0;
  bit                calm_out = 1'b0;
  int                stall_left = 0;

  function automatic logic [7:0] tile_rd(logic [7:0] id, bit obj, logic [2:0] row, bit plane);
    int base;
    base = (obj || lcd_ctl[tsdr_pkg::LCD_UNSIGNED_BIT] || id > 127) ? id * 16 :
           'h1000 + id * 16;
    return vram[(base + row * 2 + plane) % tsdr_pkg::VRAM_BYTES];
  endfunction

  function automatic int spr_left(int idx);
    if (idx >= spr_n || idx >= tsdr_pkg::MAX_SPRITES_DEF) idx = 0;
    return int'(spr[idx][23:16]) - 8;
  endfunction

  function automatic void fifo_fill(bit obj, logic [7:0] pal);
    logic [9:0] px;
    if (obj ? sp_head < tsdr_pkg::FIFO_DEPTH : bg_head < tsdr_pkg::FIFO_DEPTH) return;
    for (int i = 0; i < 8; i++) begin
      px = {pal, f_hi[7-i], f_lo[7-i]};
      if (obj) sq[i] = px;
      else bgq[i] = px;
    end
    if (obj) sp_head = 0;
    else bg_head = 0;
  endfunction

  function automatic void scan_dot();
    int e;
    if (dot == 0) spr_n = 0;
    if (dot % 2 == 0 && dot < 80 && spr_n < tsdr_pkg::MAX_SPRITES_DEF) begin
      e = dot * 2;
      if (oram[e+1] != 0 && oram[e] <= line + 16 && oram[e] > line + 8) begin
        spr[spr_n] = {oram[e], oram[e+1], oram[e+2], oram[e+3]};
        spr_n++;
      end
    end
    if (dot == 79) begin
      mode = tsdr_pkg::MODE_DRAW;
      col = 0;
      spr_fetch = 0;
      bg_head = tsdr_pkg::FIFO_DEPTH;
      sp_head = tsdr_pkg::FIFO_DEPTH;
      spr_next = 0;
      fstep = 0;
      tcol = 0;
    end
  endfunction

  function automatic void draw_dot(ref tsdr_pkg::result_t r);
    logic [31:0] s;
    logic [9:0]  px;
    logic [1:0]  color;
    logic [7:0]  pal;
    case (fstep)
      0: begin
        if (spr_fetch) begin
          s = spr[(spr_next < spr_n ? spr_next : 0) % tsdr_pkg::MAX_SPRITES_DEF];
          f_row = 8'(line - s[31:24]);
          f_id = s[15:8];
          f_flags = s[7:0];
          f_obj = 1;
        end else begin
          f_row = 8'(line + scy);
          f_id = vram[('h1800 + (f_row & 8'hf8) * 4 + tcol) % tsdr_pkg::VRAM_BYTES];
          f_obj = 0;
        end
      end
      2: f_lo = tile_rd(f_id, f_obj, f_row[2:0], 0);
      4: f_hi = tile_rd(f_id, f_obj, f_row[2:0], 1);
      6: if (!spr_fetch) tcol = (tcol + 1) & 31;
      7: begin
        if (spr_fetch) begin
          fifo_fill(1, f_flags);
          spr_next = (spr_next + 1) & 15;
          if (spr_next >= spr_n) spr_fetch = 0;
          else if (spr_left(spr_next) > col) spr_fetch = 0;
        end else begin
          fifo_fill(0, bgp);
          if (spr_next < spr_n && spr_left(spr_next) == col) spr_fetch = 1;
        end
      end
      default: ;
    endcase
    fstep = (fstep + 1) & 7;
    if (!spr_fetch && bg_head < tsdr_pkg::FIFO_DEPTH) begin
      px = bgq[bg_head];
      bg_head++;
      color = px[1:0];
      pal = px[9:2];
      if (sp_head < tsdr_pkg::FIFO_DEPTH) begin
        px = sq[sp_head];
        sp_head++;
        if (px[1:0] != 0) begin
          color = px[1:0];
          pal = px[2+tsdr_pkg::FLAG_PAL_BIT] ? obp1 : obp0;
        end
      end
      if (col < tsdr_pkg::SCREEN_WIDTH_DEF) begin
        r.pixel_valid = 1;
        r.pixel_x = 8'(col);
        r.pixel_y = 8'(line);
        if (!lcd_ctl[tsdr_pkg::LCD_ON_BIT]) r.pixel_blank = 1;
        else r.shade = 2'(pal >> (2 * color));
        col++;
      end
    end
    if (col == tsdr_pkg::SCREEN_WIDTH_DEF) mode = tsdr_pkg::MODE_HBLANK;
  endfunction

  function automatic tsdr_pkg::result_t render_step(tsdr_pkg::op_t op, logic [12:0] addr,
                                                    logic [7:0] data);
    tsdr_pkg::result_t r;
    r = '0;
    case (op)
      tsdr_pkg::OP_VWRITE: vram[addr] = data;
      tsdr_pkg::OP_OWRITE: if (addr < tsdr_pkg::OBJ_BYTES) oram[addr] = data;
      tsdr_pkg::OP_TICK: begin
        if (mode == tsdr_pkg::MODE_SCAN) scan_dot();
        else if (mode == tsdr_pkg::MODE_DRAW) draw_dot(r);
        dot++;
        if (dot >= tsdr_pkg::DOTS_PER_LINE) begin
          dot = 0;
          line = (line + 1) & 255;
          match = (line == lyc);
          if (line < tsdr_pkg::VBLANK_LINE) mode = tsdr_pkg::MODE_SCAN;
          else if (line == tsdr_pkg::VBLANK_LINE) begin
            mode = tsdr_pkg::MODE_VBLANK;
            r.vblank_pulse = 1;
          end else if (line >= tsdr_pkg::LINE_WRAP) begin
            line = 0;
            mode = tsdr_pkg::MODE_SCAN;
          end
        end
      end
      default: ;
    endcase
    r.video_mode = mode;
    r.current_line = 8'(line);
    r.line_match = match;
    return r;
  endfunction

  initial begin
    lcd_ctl = 145; scy = 0; bgp = 252; obp0 = 255; obp1 = 255; lyc = 0;
    dot = 0; line = 0; mode = tsdr_pkg::MODE_SCAN; spr_n = 0; spr_next = 0; fstep = 0;
    tcol = 0; spr_fetch = 0; bg_head = tsdr_pkg::FIFO_DEPTH; sp_head = tsdr_pkg::FIFO_DEPTH;
    col = 0; match = 0;
    f_row = 0; f_id = 0; f_lo = 0; f_hi = 0; f_flags = 0; f_obj = 0;
    foreach (spr[i]) spr[i] = '0;
    foreach (vram[i]) vram[i] = '0;
    foreach (oram[i]) oram[i] = '0;
  end

  // accepted requests and register writes update the predictor
  always @(posedge clk) begin
    row_t              row;
    tsdr_pkg::result_t r;
    if (rst_n && cfg_we) begin
      case (cfg_index)
        tsdr_pkg::CFG_LCD_CONTROL: lcd_ctl = cfg_data;
        tsdr_pkg::CFG_SCROLL_Y:    scy = cfg_data;
        tsdr_pkg::CFG_BG_PALETTE:  bgp = cfg_data;
        tsdr_pkg::CFG_OBJ_PAL0:    obp0 = cfg_data;
        tsdr_pkg::CFG_OBJ_PAL1:    obp1 = cfg_data;
        tsdr_pkg::CFG_LINE_CMP:    lyc = cfg_data;
        default: ;
      endcase
    end
    if (rst_n && in_valid && !in_stall) begin
      row = typed_q.pop_front();
      r = render_step(tsdr_pkg::op_t'(in_req_type), in_mem_addr, in_mem_data);
      pending_px.push_back(row.typed ? row.res : r);
    end
  end

  task automatic chk(string name, int e, int a);
    if (e != a) begin
      errors++;
      if (errors <= 40)
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, e, a);
    end
  endtask

  always @(posedge clk) begin
    tsdr_pkg::result_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_px.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, got line %0d", $time,
                 out_current_line);
      end else begin
        e = pending_px.pop_front();
        chk("pixel_valid", e.pixel_valid, out_pixel_valid);
        chk("pixel_x", e.pixel_x, out_pixel_x);
        chk("pixel_y", e.pixel_y, out_pixel_y);
        chk("shade", e.shade, out_shade);
        chk("pixel_blank", e.pixel_blank, out_pixel_blank);
        chk("video_mode", e.video_mode, out_video_mode);
        chk("current_line", e.current_line, out_current_line);
        chk("line_match", e.line_match, out_line_match);
        chk("vblank_pulse", e.vblank_pulse, out_vblank_pulse);
      end
    end
  end

  // receiver stalls: short random ones, an occasional long one, calm stretches
  always @(posedge clk) begin
    if (!rst_n || calm_out) out_stall <= 1'b0;
    else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall <= 1'b1;
    end else if ($urandom_range(0, 499) == 0) begin
      stall_left <= $urandom_range(10, 60);
      out_stall <= 1'b1;
    end else out_stall <= ($urandom_range(0, 99) < 25);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  task automatic send(row_t row);
    int gap;
    gap = 0;
    if (!calm_in) begin
      case ($urandom_range(0, 99)) inside
        [0:59]:  gap = 0;
        [60:94]: gap = $urandom_range(1, 3);
        default: gap = $urandom_range(4, 40);
      endcase
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    typed_q.push_back(row);
    in_valid <= 1'b1;
    in_req_type <= row.op;
    in_mem_addr <= row.addr;
    in_mem_data <= row.data;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic send_op(tsdr_pkg::op_t op, logic [12:0] addr, logic [7:0] data);
    row_t row;
    row.op = op;
    row.addr = addr;
    row.data = data;
    row.typed = 0;
    row.res = '0;
    send(row);
  endtask

  // map entries and sprite tile ids stay within the tiles that were filled
  task automatic send_random(int tick_pct);
    int            pick;
    tsdr_pkg::op_t op;
    logic [12:0]   addr;
    logic [7:0]    data;
    pick = $urandom_range(0, 99);
    addr = 13'($urandom);
    data = 8'($urandom);
    if (pick < tick_pct) op = tsdr_pkg::OP_TICK;
    else if (pick < tick_pct + (100 - tick_pct) / 2) begin
      op = tsdr_pkg::OP_VWRITE;
      if (addr >= MAP_BASE && addr <= MAP_END) data = 8'h80 | 8'($urandom_range(0, 3));
    end else if (pick < 97) begin
      op = tsdr_pkg::OP_OWRITE;
      if ($urandom_range(0, 3) != 0) addr = 13'($urandom_range(0, 175));
      if (addr[1:0] == 2'd2) data = 8'h80 | 8'($urandom_range(0, 3));
    end else op = tsdr_pkg::OP_NOP;
    send_op(op, addr, data);
  endtask

  task automatic settle_and_config(logic [7:0] v [6]);
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_px.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
    for (int i = 0; i < 6; i++) begin
      cfg_we <= 1'b1;
      cfg_index <= 3'(i);
      cfg_data <= v[i];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic random_run(int n, int tick_pct);
    for (int i = 0; i < n; i++) begin
      if (i % 300 == 0) begin
        calm_in = ($urandom_range(0, 3) == 0);
        calm_out = ($urandom_range(0, 3) == 0);
      end
      send_random(tick_pct);
    end
  endtask

  initial begin
    row_t              dir [12];
    tsdr_pkg::result_t idle_res;
    logic [7:0]        regs [6];
    logic [7:0]        oy;
    int                map_rows [3];
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // fill tiles 128 to 131, the map rows that the first lines reach and all objects
    calm_in = 1;
    map_rows = '{0, 1, 31};
    for (int a = 0; a < 64; a++)
      send_op(tsdr_pkg::OP_VWRITE, TILE_BASE + 13'(a), 8'($urandom));
    foreach (map_rows[r])
      for (int c = 0; c < 32; c++)
        send_op(tsdr_pkg::OP_VWRITE, MAP_BASE + 13'(map_rows[r] * 32 + c),
                8'h80 | 8'($urandom_range(0, 3)));
    for (int a = 0; a < tsdr_pkg::OBJ_BYTES; a += 4) begin
      oy = 8'($urandom_range(0, 170));
      send_op(tsdr_pkg::OP_OWRITE, 13'(a), oy);
      send_op(tsdr_pkg::OP_OWRITE, 13'(a + 1), 8'($urandom_range(0, 175)));
      send_op(tsdr_pkg::OP_OWRITE, 13'(a + 2), 8'h80 | 8'($urandom_range(0, 3)));
      send_op(tsdr_pkg::OP_OWRITE, 13'(a + 3), 8'($urandom));
    end
    calm_in = 0;

    // line 0, dot 0, object scan: every status-only result is the same
    idle_res = '0;
    idle_res.video_mode = tsdr_pkg::MODE_SCAN;
    dir[0]  = '{tsdr_pkg::OP_VWRITE, 13'h1fff, 8'hff, 1, idle_res};
    dir[1]  = '{tsdr_pkg::OP_VWRITE, 13'h0000, 8'h00, 1, idle_res};
    dir[2]  = '{tsdr_pkg::OP_OWRITE, 13'd159, 8'hff, 1, idle_res};
    dir[3]  = '{tsdr_pkg::OP_OWRITE, 13'd160, 8'h00, 1, idle_res};
    dir[4]  = '{tsdr_pkg::OP_OWRITE, 13'h1fff, 8'h00, 1, idle_res};
    dir[5]  = '{tsdr_pkg::OP_NOP, 13'h1fff, 8'hff, 1, idle_res};
    dir[6]  = '{tsdr_pkg::OP_NOP, 13'h0000, 8'h00, 1, idle_res};
    dir[7]  = '{tsdr_pkg::OP_TICK, 13'h0000, 8'h00, 1, idle_res};
    dir[8]  = '{tsdr_pkg::OP_TICK, 13'h1fff, 8'hff, 1, idle_res};
    dir[9]  = '{tsdr_pkg::OP_OWRITE, 13'd0, 8'd16, 0, idle_res};
    dir[10] = '{tsdr_pkg::OP_OWRITE, 13'd1, 8'd8, 0, idle_res};
    dir[11] = '{tsdr_pkg::OP_TICK, 13'h0000, 8'h00, 0, idle_res};
    foreach (dir[i]) send(dir[i]);
    for (int i = 0; i < 12; i++)
      send_op(tsdr_pkg::OP_TICK, 13'($urandom), 8'($urandom));

    random_run(400, 80);

    regs = '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00};
    settle_and_config(regs);
    random_run(300, 90);

    // all-ones registers but the line compare, coincidence on the second line advance
    regs = '{8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'd2};
    settle_and_config(regs);
    random_run(350, 98);

    regs = '{8'($urandom) | 8'h80, 8'($urandom_range(0, 7)), 8'($urandom), 8'($urandom),
             8'($urandom), 8'($urandom_range(0, 3))};
    settle_and_config(regs);
    random_run(300, 95);

    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_px.size() != 0) @(posedge clk);
    repeat (5) @(posedge clk);
    if (errors == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule

[filelist.f]
hdl/tsdr_pkg.sv
hdl/tsdr_ram.sv
hdl/tsdr_front.sv
hdl/tsdr_back.sv
hdl/tile_sprite_dot_renderer_top.sv
hdl/tsdr_checker.sv
tb/sv/tb_top.sv
